[sv/adrc_pkg.sv]
// ============================================================================
// adrc_pkg
// Shared types, register indexes, fixed-point constants and helpers for the
// dynamic range compressor.
// ============================================================================
package adrc_pkg;

    localparam int NUM_CHANNELS = 2;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;
    localparam int SAMPLE_W     = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_MASK = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ATTACK_COEF  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_COEF = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_DB = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RATIO        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAKEUP_DB    = 3'd5;

    // Cubic log2 approximation over [0.5, 1), Q16 coefficients.
    localparam logic signed [33:0] LOG_C3 = 34'sd80708;
    localparam logic signed [33:0] LOG_C2 = 34'sd269912;
    localparam logic signed [33:0] LOG_C1 = 34'sd394656;
    localparam logic signed [33:0] LOG_C0 = 34'sd205388;
    // 20*log10(2) scaled to turn Q16 log2 into Q8.8 dB after a 24-bit shift.
    localparam logic signed [21:0] DB_PER_LOG2 = 22'sd394566;
    // log2(10)/20 in Q16, turns Q8.8 dB into Q24 log2.
    localparam logic signed [21:0] LOG2_PER_DB = 22'sd10885;
    // Cubic 2^x approximation, Q16 coefficients.
    localparam logic [17:0] EXP_C3 = 18'd5205;
    localparam logic [17:0] EXP_C2 = 18'd14706;
    localparam logic [17:0] EXP_C1 = 18'd45617;
    localparam logic [17:0] EXP_C0 = 18'd65536;

    localparam logic signed [15:0] LEVEL_FLOOR = -16'sd32768;
    localparam logic [12:0]        RATIO_ONE   = 13'd256;

    typedef enum logic [4:0] {
        S_IDLE, S_DIV, S_NORM, S_P1, S_P2, S_P3, S_DB, S_LVL,
        S_SM1, S_SM2, S_SM3, S_GN, S_GL, S_FR, S_M1, S_M2, S_M3,
        S_O0, S_O1, S_O2, S_DONE
    } state_t;

    // Saturate a wide signed value to 16 bits.
    function automatic logic signed [15:0] sat16(input logic signed [55:0] v);
        logic signed [15:0] r;
        if (v > 56'sd32767)
            r = 16'sh7FFF;
        else if (v < -56'sd32768)
            r = 16'sh8000;
        else
            r = v[15:0];
        return r;
    endfunction

endpackage

[sv/adrc_ifs.sv]
// ============================================================================
// adrc channel interfaces
// Valid/ready channels for input frames, result frames and register writes.
// ============================================================================
interface adrc_sample_if;
    logic                                     valid;
    logic                                     ready;
    logic signed [adrc_pkg::SAMPLE_W-1:0]     sample_ch0;
    logic signed [adrc_pkg::SAMPLE_W-1:0]     sample_ch1;

    modport source (output valid, output sample_ch0, output sample_ch1, input ready);
    modport sink   (input valid, input sample_ch0, input sample_ch1, output ready);
endinterface

interface adrc_result_if;
    logic                                     valid;
    logic                                     ready;
    logic signed [adrc_pkg::SAMPLE_W-1:0]     out_ch0;
    logic signed [adrc_pkg::SAMPLE_W-1:0]     out_ch1;

    modport source (output valid, output out_ch0, output out_ch1, input ready);
    modport sink   (input valid, input out_ch0, input out_ch1, output ready);
endinterface

interface adrc_cfg_if;
    logic                                     valid;
    logic                                     ready;
    logic [adrc_pkg::CFG_IDX_W-1:0]           index;
    logic [adrc_pkg::CFG_DATA_W-1:0]          data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[sv/audio_dynamic_range_compressor_top.sv]
// ============================================================================
// audio_dynamic_range_compressor_top
// Feedforward log-domain stereo compressor built around one shared multiplier.
// ============================================================================
// Usage:
// - in_ch carries one stereo frame (Q1.15) per transaction; out_ch returns
//   exactly one compressed frame per input transaction, in order.
// - cfg writes one register per transaction: 0 channel mask, 1 attack coef,
//   2 release coef, 3 threshold, 4 ratio, 5 makeup. Other indexes are ignored.
//   A ratio write above 1:1 starts a restoring division for the
//   slope; cfg and in_ch are not ready during it.
// - A frame is accepted in IDLE and steps through NORM, P1-P3, DB and LVL
//   (these five skipped when the level sum is zero), SM1-SM3, GN, GL, FR,
//   M1-M3, O0-O2 and DONE, which loads the result into the output register.
//   One signed 34x22 multiplier with a registered product serves the log,
//   smoothing, gain, exp and output products; the next frame waits for IDLE.
// - The output register is separate from the datapath, so a new frame is
//   taken while the previous result waits; the final step holds until the
//   output register is free when the receiver stalls.
// - Reset clears the sequencer, the output valid, the registers to their
//   defaults and the smoothed level to -128 dB. No clearing pass is needed.
// ============================================================================
module audio_dynamic_range_compressor_top (
    input  logic                clk,
    input  logic                rst_n,
    adrc_sample_if.sink         in_ch,
    adrc_result_if.source       out_ch,
    adrc_cfg_if.sink            cfg
);
    import adrc_pkg::*;

    // Sequencer state.
    state_t state_reg, state_next;

    // Configuration registers.
    logic [NUM_CHANNELS-1:0] mask_reg, mask_next;
    logic [15:0]             attack_reg, attack_next;
    logic [15:0]             release_reg, release_next;
    logic signed [15:0]      thr_reg, thr_next;
    logic [12:0]             ratio_reg, ratio_next;
    logic signed [13:0]      makeup_reg, makeup_next;
    logic [15:0]             slope_reg, slope_next;

    // Divider state for the slope.
    logic [12:0]             rem_reg, rem_next;
    logic [14:0]             quot_reg, quot_next;
    logic [3:0]              div_cnt_reg, div_cnt_next;

    // Loudness state.
    logic signed [15:0]      smooth_reg, smooth_next;

    // Per-frame datapath registers.
    logic signed [15:0]      s0_reg, s0_next;
    logic signed [15:0]      s1_reg, s1_next;
    logic [16:0]             mag_reg, mag_next;
    logic [19:0]             frac_reg, frac_next;
    logic [4:0]              blen_reg, blen_next;
    logic signed [15:0]      lvl_reg, lvl_next;
    logic [15:0]             coef_reg, coef_next;
    logic signed [55:0]      acc_reg, acc_next;
    logic signed [7:0]       ip_reg, ip_next;
    logic [15:0]             f16_reg, f16_next;
    logic [32:0]             gain_reg, gain_next;
    logic signed [15:0]      res0_reg, res0_next;
    logic signed [15:0]      res1_reg, res1_next;

    // Shared multiplier.
    logic signed [33:0]      mul_a;
    logic signed [21:0]      mul_b;
    logic signed [55:0]      prod_reg;

    // Output register.
    logic                    out_valid_reg;
    logic signed [15:0]      out0_reg, out1_reg;

    logic in_acc, cfg_acc, slot_free;

    assign in_ch.ready  = (state_reg == S_IDLE) && !cfg.valid;
    assign cfg.ready    = (state_reg == S_IDLE);
    assign in_acc       = in_ch.valid && in_ch.ready;
    assign cfg_acc      = cfg.valid && cfg.ready;
    assign slot_free    = !out_valid_reg || out_ch.ready;

    assign out_ch.valid   = out_valid_reg;
    assign out_ch.out_ch0 = out0_reg;
    assign out_ch.out_ch1 = out1_reg;

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cfg_acc && cfg.index == REG_RATIO && cfg.data[12:0] > RATIO_ONE)
                    state_next = S_DIV;
                else if (in_acc)
                    state_next = S_NORM;
            end
            S_DIV:  if (div_cnt_reg == 4'd15) state_next = S_IDLE;
            S_NORM: state_next = (mag_reg == '0) ? S_SM1 : S_P1;
            S_P1:   state_next = S_P2;
            S_P2:   state_next = S_P3;
            S_P3:   state_next = S_DB;
            S_DB:   state_next = S_LVL;
            S_LVL:  state_next = S_SM1;
            S_SM1:  state_next = S_SM2;
            S_SM2:  state_next = S_SM3;
            S_SM3:  state_next = S_GN;
            S_GN:   state_next = S_GL;
            S_GL:   state_next = S_FR;
            S_FR:   state_next = S_M1;
            S_M1:   state_next = S_M2;
            S_M2:   state_next = S_M3;
            S_M3:   state_next = S_O0;
            S_O0:   state_next = S_O1;
            S_O1:   state_next = S_O2;
            S_O2:   state_next = S_DONE;
            S_DONE: if (slot_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath and multiplier operand selection.
    always_comb
    begin
        logic signed [16:0] sum;
        logic signed [55:0] sh16, sh20, sh24;
        logic signed [33:0] y;
        logic signed [33:0] boff;
        logic signed [16:0] diff;
        logic [17:0]        mant;
        logic [13:0]        rem2;
        logic               qbit;
        logic [4:0]         blen;
        logic [36:0]        mwide;
        logic [3:0]         ipc;
        logic [7:0]         negip;

        mask_next    = mask_reg;
        attack_next  = attack_reg;
        release_next = release_reg;
        thr_next     = thr_reg;
        ratio_next   = ratio_reg;
        makeup_next  = makeup_reg;
        slope_next   = slope_reg;
        rem_next     = rem_reg;
        quot_next    = quot_reg;
        div_cnt_next = div_cnt_reg;
        smooth_next  = smooth_reg;
        s0_next      = s0_reg;
        s1_next      = s1_reg;
        mag_next     = mag_reg;
        frac_next    = frac_reg;
        blen_next    = blen_reg;
        lvl_next     = lvl_reg;
        coef_next    = coef_reg;
        acc_next     = acc_reg;
        ip_next      = ip_reg;
        f16_next     = f16_reg;
        gain_next    = gain_reg;
        res0_next    = res0_reg;
        res1_next    = res1_reg;
        mul_a        = '0;
        mul_b        = '0;

        sh16 = prod_reg >>> 16;
        sh20 = prod_reg >>> 20;
        sh24 = prod_reg >>> 24;
        sum  = '0;
        y    = '0;
        boff = '0;
        diff = '0;
        mant = '0;
        rem2 = '0;
        qbit = 1'b0;
        blen = '0;
        mwide = '0;
        ipc  = '0;
        negip = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (cfg_acc)
                begin
                    case (cfg.index)
                        REG_CHANNEL_MASK: mask_next    = cfg.data[NUM_CHANNELS-1:0];
                        REG_ATTACK_COEF:  attack_next  = cfg.data;
                        REG_RELEASE_COEF: release_next = cfg.data;
                        REG_THRESHOLD_DB: thr_next     = $signed(cfg.data);
                        REG_RATIO:
                        begin
                            ratio_next   = cfg.data[12:0];
                            rem_next     = cfg.data[12:0] - RATIO_ONE;
                            quot_next    = '0;
                            div_cnt_next = '0;
                            slope_next   = '0;
                        end
                        REG_MAKEUP_DB:    makeup_next  = $signed(cfg.data[13:0]);
                        default: ;
                    endcase
                end
                else if (in_acc)
                begin
                    s0_next = in_ch.sample_ch0;
                    s1_next = in_ch.sample_ch1;
                    sum = (mask_reg[0] ? {in_ch.sample_ch0[15], in_ch.sample_ch0} : 17'sd0)
                        + (mask_reg[1] ? {in_ch.sample_ch1[15], in_ch.sample_ch1} : 17'sd0);
                    mag_next = sum[16] ? 17'(-sum) : 17'(sum);
                end
            end
            S_DIV:
            begin
                // One quotient bit per cycle, restoring.
                rem2 = {rem_reg, 1'b0};
                qbit = (rem2 >= {1'b0, ratio_reg});
                rem_next  = qbit ? 13'(rem2 - {1'b0, ratio_reg}) : rem2[12:0];
                quot_next = {quot_reg[13:0], qbit};
                div_cnt_next = div_cnt_reg + 4'd1;
                if (div_cnt_reg == 4'd15)
                    slope_next = {quot_reg, qbit};
            end
            S_NORM:
            begin
                for (int i = 0; i < 17; i++)
                    if (mag_reg[i]) blen = 5'(i + 1);
                blen_next = blen;
                mwide = {20'd0, mag_reg} << 20;
                frac_next = 20'(mwide >> blen);
                if (mag_reg == '0)
                    lvl_next = LEVEL_FLOOR;
            end
            S_P1:
            begin
                mul_a = LOG_C3;
                mul_b = $signed({2'b00, frac_reg});
            end
            S_P2:
            begin
                mul_a = sh20[33:0] - LOG_C2;
                mul_b = $signed({2'b00, frac_reg});
            end
            S_P3:
            begin
                mul_a = sh20[33:0] + LOG_C1;
                mul_b = $signed({2'b00, frac_reg});
            end
            S_DB:
            begin
                y    = sh20[33:0] - LOG_C0;
                boff = $signed({29'd0, blen_reg}) - 34'sd15;
                mul_a = y + (boff <<< 16);
                mul_b = DB_PER_LOG2;
            end
            S_LVL:
            begin
                lvl_next = sat16(sh24);
            end
            S_SM1:
            begin
                coef_next = (lvl_reg >= smooth_reg) ? attack_reg : release_reg;
                mul_a = $signed({18'd0, coef_next});
                mul_b = 22'(smooth_reg);
            end
            S_SM2:
            begin
                acc_next = prod_reg;
                mul_a = 34'sd65536 - $signed({18'd0, coef_reg});
                mul_b = 22'(lvl_reg);
            end
            S_SM3:
            begin
                smooth_next = sat16((acc_reg + prod_reg) >>> 16);
            end
            S_GN:
            begin
                diff = 17'(smooth_reg) - 17'(thr_reg);
                if (smooth_reg > thr_reg)
                begin
                    mul_a = 34'(diff);
                    mul_b = $signed({6'd0, slope_reg});
                end
            end
            S_GL:
            begin
                mul_a = 34'(makeup_reg) - sh16[33:0];
                mul_b = LOG2_PER_DB;
            end
            S_FR:
            begin
                ip_next  = sh24[7:0];
                f16_next = prod_reg[23:8];
                mul_a = $signed({18'd0, prod_reg[23:8]});
                mul_b = $signed({4'd0, EXP_C3});
            end
            S_M1:
            begin
                mant  = EXP_C2 + prod_reg[33:16];
                mul_a = $signed({18'd0, f16_reg});
                mul_b = $signed({4'd0, mant});
            end
            S_M2:
            begin
                mant  = EXP_C1 + prod_reg[33:16];
                mul_a = $signed({18'd0, f16_reg});
                mul_b = $signed({4'd0, mant});
            end
            S_M3:
            begin
                mant = EXP_C0 + prod_reg[33:16];
                ipc  = (ip_reg > 8'sd15) ? 4'd15 : ip_reg[3:0];
                negip = 8'(-ip_reg);
                if (!ip_reg[7])
                    gain_next = {15'd0, mant} << ipc;
                else if (ip_reg < -8'sd17)
                    gain_next = '0;
                else
                    gain_next = {15'd0, mant} >> negip[4:0];
            end
            S_O0:
            begin
                mul_a = $signed({1'b0, gain_reg});
                mul_b = 22'(s0_reg);
            end
            S_O1:
            begin
                res0_next = mask_reg[0] ? sat16((prod_reg + 56'sd32768) >>> 16) : s0_reg;
                mul_a = $signed({1'b0, gain_reg});
                mul_b = 22'(s1_reg);
            end
            S_O2:
            begin
                res1_next = mask_reg[1] ? sat16((prod_reg + 56'sd32768) >>> 16) : s1_reg;
            end
            S_DONE: ;
            default: ;
        endcase
    end

    // Control and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mask_reg      <= NUM_CHANNELS'(3);
            attack_reg    <= '0;
            release_reg   <= '0;
            thr_reg       <= '0;
            ratio_reg     <= RATIO_ONE;
            makeup_reg    <= '0;
            slope_reg     <= '0;
            div_cnt_reg   <= '0;
            smooth_reg    <= LEVEL_FLOOR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            mask_reg    <= mask_next;
            attack_reg  <= attack_next;
            release_reg <= release_next;
            thr_reg     <= thr_next;
            ratio_reg   <= ratio_next;
            makeup_reg  <= makeup_next;
            slope_reg   <= slope_next;
            div_cnt_reg <= div_cnt_next;
            smooth_reg  <= smooth_next;
            if (state_reg == S_DONE && slot_free)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        s0_reg   <= s0_next;
        s1_reg   <= s1_next;
        mag_reg  <= mag_next;
        frac_reg <= frac_next;
        blen_reg <= blen_next;
        lvl_reg  <= lvl_next;
        coef_reg <= coef_next;
        acc_reg  <= acc_next;
        ip_reg   <= ip_next;
        f16_reg  <= f16_next;
        gain_reg <= gain_next;
        res0_reg <= res0_next;
        res1_reg <= res1_next;
        prod_reg <= 56'(mul_a * mul_b);
        if (state_reg == S_DONE && slot_free)
        begin
            out0_reg <= res0_reg;
            out1_reg <= res1_reg;
        end
    end

endmodule

[sv/adrc_checker.sv]
// ============================================================================
// adrc_checker
// Port-level checks of the compressor's sequencing, bound to the top level.
// ============================================================================
module adrc_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_ready,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic                             cfg_valid,
    input logic                             cfg_ready,
    input logic [adrc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input logic [adrc_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import adrc_pkg::*;

    // A frame occupies the datapath, so the input closes right after it.
    a_busy_after_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input ready right after a frame transaction");

    // A ratio write above unity starts the slope division.
    a_busy_after_ratio: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_ready && cfg_index == REG_RATIO && cfg_data[12:0] > RATIO_ONE)
        |=> (!in_ready && !cfg_ready))
        else $error("ports ready during slope division");

    // A frame and a register write never complete together.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_valid && in_ready && cfg_valid && cfg_ready))
        else $error("frame and register write in the same cycle");

    // A result is held until taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result dropped before transaction");

endmodule

bind audio_dynamic_range_compressor_top adrc_checker u_adrc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cfg_valid (cfg.valid),
    .cfg_ready (cfg.ready),
    .cfg_index (cfg.index),
    .cfg_data  (cfg.data)
);
